[rtl/core/pdr_pkg.sv]
package pdr_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int DATA_W      = 64;
  localparam int LEN_W       = 4;
  localparam int CNT_W       = 4;
  localparam int SLOT_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int VALUE_BYTES = 4;
  localparam int BITOFF_W    = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PAIR_D = 3'd4;

  typedef struct packed {
    logic [15:0] object_index;
    logic [7:0]  sub_index;
    logic [7:0]  bitlen;
  } map_entry_t;

  typedef struct packed {
    logic [DATA_W-1:0] frame_bytes;
    logic [LEN_W-1:0]  frame_length;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        object_index;
    logic [7:0]         sub_index;
    logic [VALUE_W-1:0] field_value;
    logic               short_frame;
    logic               last;
  } out_item_t;

  // Result of one pass through the extraction unit.
  typedef struct packed {
    logic                fits;
    logic [VALUE_W-1:0]  value;
    logic [BITOFF_W-1:0] bit_off_next;
  } ext_res_t;

endpackage

[rtl/core/pdr_map_table.sv]
module pdr_map_table #(
  parameter int MAX_ENTRIES = 8,
  parameter int IDX_W       = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [IDX_W-1:0]                  rd_idx,
  output pdr_pkg::map_entry_t               rd_entry,
  output logic [pdr_pkg::CNT_W-1:0]         map_count
);

  logic [pdr_pkg::CNT_W-1:0] map_count_r;
  pdr_pkg::map_entry_t       entries_r [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_count_r <= '0;
      for (int e = 0; e < MAX_ENTRIES; e++) begin
        entries_r[e] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == pdr_pkg::REG_MAP_COUNT) begin
        map_count_r <= cfg_wdata[pdr_pkg::CNT_W-1:0];
      end
      // Each pair register carries two entries; the even entry sits in the low word.
      for (int e = 0; e < MAX_ENTRIES; e++) begin
        if (cfg_index == pdr_pkg::REG_MAP_PAIR_A + pdr_pkg::CFG_IDX_W'(e >> 1)) begin
          entries_r[e] <= (e % 2 == 1) ? cfg_wdata[63:32] : cfg_wdata[31:0];
        end
      end
    end
  end

  assign rd_entry  = entries_r[rd_idx];
  assign map_count = map_count_r;

endmodule

[rtl/core/pdr_extract.sv]
module pdr_extract (
  input  logic [pdr_pkg::DATA_W-1:0]   frame_bytes,
  input  logic [pdr_pkg::LEN_W-1:0]    frame_length,
  input  logic [pdr_pkg::BITOFF_W-1:0] bit_off,
  input  logic [7:0]                   bitlen,
  output pdr_pkg::ext_res_t            res
);

  logic [4:0]                  nbytes;
  logic [7:0]                  start;
  logic [8:0]                  end_byte;
  logic [2:0]                  take;
  logic [pdr_pkg::DATA_W-1:0]  shifted;
  logic [pdr_pkg::VALUE_W-1:0] mask;
  logic                        fits;

  assign nbytes   = bitlen[7:3];
  assign start    = bit_off[pdr_pkg::BITOFF_W-1:3];
  assign end_byte = {1'b0, start} + {4'b0, nbytes};
  assign fits     = end_byte <= {5'b0, frame_length};
  assign take     = (nbytes > 5'd4) ? 3'd4 : nbytes[2:0];

  // Only the low three bits of the start byte matter: a fitting entry never
  // starts past the last payload byte with data left to copy.
  assign shifted = frame_bytes >> {start[2:0], 3'b000};

  always_comb begin
    for (int b = 0; b < pdr_pkg::VALUE_BYTES; b++) begin
      mask[b*8 +: 8] = (3'(b) < take) ? 8'hFF : 8'h00;
    end
  end

  assign res.fits         = fits;
  assign res.value        = fits ? (shifted[pdr_pkg::VALUE_W-1:0] & mask) : '0;
  assign res.bit_off_next = bit_off + {3'b0, bitlen};

endmodule

[rtl/core/pdo_receive_demapper_unit.sv]
// Channel  | Direction | Signals                      | Beat taken when
// ---------+-----------+------------------------------+---------------------------
// input    | in        | in_valid, in_data, in_stall  | in_valid && !in_stall
// result   | out       | out_valid, out_data, out_stall| out_valid && !out_stall
// config   | in        | cfg_wr_en, cfg_index, cfg_wdata | cfg_wr_en
//
// A frame is loaded first, then the walk gives one result per mapping entry up
// to the first misfit, one per cycle unless results stall. The sequencer walks
// the entries through one shared extraction unit (byte shifter and fit compare).
// in_stall is high while entries of the current frame remain to be processed.
// A stall on the result side while a result is held keeps the result register and pauses the walk.
// Reset is synchronous and clears the mapping table, the count and all control.
module pdo_receive_demapper_unit #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pdr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pdr_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                          state_r, state_nxt;
  logic [pdr_pkg::DATA_W-1:0]    data_r, data_nxt;
  logic [pdr_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [pdr_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [pdr_pkg::CNT_W-1:0]     k_r, k_nxt;
  logic [pdr_pkg::BITOFF_W-1:0]  bit_off_r, bit_off_nxt;
  logic                          out_valid_r, out_valid_nxt;
  pdr_pkg::out_item_t            out_data_r, out_data_nxt;

  pdr_pkg::map_entry_t           entry;
  logic [pdr_pkg::CNT_W-1:0]     map_count;
  logic [pdr_pkg::CNT_W-1:0]     count_clamped;
  logic [pdr_pkg::LEN_W-1:0]     len_clamped;
  pdr_pkg::ext_res_t             ext;
  pdr_pkg::out_item_t            emit_item;
  logic                          in_take;
  logic                          out_take;
  logic                          emit;

  pdr_map_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_map_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rd_idx    (k_r[IDX_W-1:0]),
    .rd_entry  (entry),
    .map_count (map_count)
  );

  pdr_extract u_extract (
    .frame_bytes  (data_r),
    .frame_length (len_r),
    .bit_off      (bit_off_r),
    .bitlen       (entry.bitlen),
    .res          (ext)
  );

  assign in_stall  = (state_r == ST_RUN);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign emit      = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign count_clamped = (map_count > pdr_pkg::CNT_W'(MAX_ENTRIES)) ?
                         pdr_pkg::CNT_W'(MAX_ENTRIES) : map_count;
  assign len_clamped   = (in_data.frame_length > pdr_pkg::LEN_W'(pdr_pkg::FRAME_BYTES)) ?
                         pdr_pkg::LEN_W'(pdr_pkg::FRAME_BYTES) : in_data.frame_length;

  always_comb begin
    emit_item.slot         = k_r[pdr_pkg::SLOT_W-1:0];
    emit_item.object_index = entry.object_index;
    emit_item.sub_index    = entry.sub_index;
    emit_item.field_value  = ext.value;
    emit_item.short_frame  = !ext.fits;
    emit_item.last         = !ext.fits || (k_r + 1'b1 == count_r);
  end

  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    len_nxt       = len_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    bit_off_nxt   = bit_off_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          data_nxt    = in_data.frame_bytes;
          len_nxt     = len_clamped;
          count_nxt   = count_clamped;
          k_nxt       = '0;
          bit_off_nxt = '0;
          // An empty table produces no results at all.
          state_nxt   = (count_clamped != '0) ? ST_RUN : ST_IDLE;
        end
      end
      ST_RUN: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = emit_item;
          k_nxt         = k_r + 1'b1;
          bit_off_nxt   = ext.bit_off_next;
          if (emit_item.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      k_r         <= '0;
      bit_off_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      bit_off_r   <= bit_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
  end

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> (count_r != '0) && (k_r < count_r))
    else $error("sequencer running past the entry count");

  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.short_frame |-> out_data.last && (out_data.field_value == '0))
    else $error("short-frame result not final or carries a value");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit && emit_item.last |=> state_r == ST_IDLE)
    else $error("sequencer kept running after the final result");

  a_busy_when_running: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> in_stall && !in_take)
    else $error("input taken while entries remain");

endmodule

[tb/tb_top.sv]
module tb_top;

  localparam int MAX_ENTRIES = 8;
  localparam int CLK_HALF    = 4;
  localparam int SETTLE_CYC  = 2 * (1 + MAX_ENTRIES) + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYC    = 250;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 31;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    pdr_pkg::in_item_t beat;
    int unsigned       gap;
    bit                drain;
  } frame_job_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  pdr_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  pdr_pkg::out_item_t             out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the mapping registers, updated on every write beat.
  logic [pdr_pkg::CNT_W-1:0] map_count_q;
  pdr_pkg::map_entry_t       map_tbl [MAX_ENTRIES];
  // Table that the stimulus side is about to load.
  pdr_pkg::map_entry_t       plan_tbl [MAX_ENTRIES];

  frame_job_t          frame_queue [$];
  pdr_pkg::out_item_t  demap_expect [$];

  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;
  int unsigned frames_queued = 0;
  int unsigned frames_taken  = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned holds_done    = 0;
  bit          in_taken      = 1'b0;
  bit          out_taken     = 1'b0;
  bit          idle_on       = 1'b1;

  int unsigned gap_left    = 0;
  bit          gap_loaded  = 1'b0;
  int unsigned stall_left  = 0;
  bit          stall_loaded = 1'b0;
  int unsigned hold_left   = 0;

  pdo_receive_demapper_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_error(string msg);
    if (err_cnt < MAX_PRINTS) begin
      $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    end
    err_cnt++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s mismatch: got %h, expected %h", name, got, want));
    end
  endtask

  // Walks the mapping table over one frame and queues every result it causes.
  function automatic void predict_demap(pdr_pkg::in_item_t beat);
    int unsigned        len, cnt, bit_off, nbytes, start_byte, take;
    bit                 fits;
    pdr_pkg::out_item_t r;
    len = (beat.frame_length > pdr_pkg::FRAME_BYTES) ? pdr_pkg::FRAME_BYTES :
          int'(beat.frame_length);
    cnt = (map_count_q > MAX_ENTRIES) ? MAX_ENTRIES : int'(map_count_q);
    bit_off = 0;
    for (int k = 0; k < cnt; k++) begin
      nbytes     = int'(map_tbl[k].bitlen) / 8;
      start_byte = bit_off / 8;
      fits       = (start_byte + nbytes) <= len;
      r              = '0;
      r.slot         = pdr_pkg::SLOT_W'(k);
      r.object_index = map_tbl[k].object_index;
      r.sub_index    = map_tbl[k].sub_index;
      if (fits) begin
        take = (nbytes > pdr_pkg::VALUE_BYTES) ? pdr_pkg::VALUE_BYTES : nbytes;
        for (int b = 0; b < take; b++) begin
          r.field_value[b*8 +: 8] = beat.frame_bytes[(start_byte + b)*8 +: 8];
        end
      end
      r.short_frame = !fits;
      r.last        = !fits || (k + 1 == cnt);
      demap_expect.push_back(r);
      if (!fits) break;
      bit_off += int'(map_tbl[k].bitlen);
    end
  endfunction

  task automatic check_result(pdr_pkg::out_item_t got);
    pdr_pkg::out_item_t want;
    if (demap_expect.size() == 0) begin
      report_error($sformatf("result with nothing expected: slot %0d index %h",
                             got.slot, got.object_index));
      return;
    end
    want = demap_expect.pop_front();
    compare_field("slot", 32'(got.slot), 32'(want.slot));
    compare_field("object_index", 32'(got.object_index), 32'(want.object_index));
    compare_field("sub_index", 32'(got.sub_index), 32'(want.sub_index));
    compare_field("field_value", got.field_value, want.field_value);
    compare_field("short_frame", 32'(got.short_frame), 32'(want.short_frame));
    compare_field("last", 32'(got.last), 32'(want.last));
  endtask

  // Monitor: all sampling happens here, at the rising edge.
  always @(posedge clk) begin
    int pair;
    cycle_cnt++;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (!rst_n) begin
      map_count_q = '0;
      foreach (map_tbl[k]) map_tbl[k] = '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == pdr_pkg::REG_MAP_COUNT) begin
        map_count_q = cfg_wdata[pdr_pkg::CNT_W-1:0];
      end else if (cfg_index <= pdr_pkg::REG_MAP_PAIR_D) begin
        pair = int'(cfg_index) - int'(pdr_pkg::REG_MAP_PAIR_A);
        map_tbl[2*pair]     = cfg_wdata[31:0];
        map_tbl[2*pair + 1] = cfg_wdata[63:32];
      end
    end
    if (in_taken) begin
      frames_taken++;
      predict_demap(in_data);
    end
    if (out_taken) begin
      results_seen++;
      check_result(out_data);
    end
  end

  // Frame driver: waits out each frame's gap, holds the beat until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_taken) gap_loaded = 1'b0;
      if (in_valid && !in_taken) begin
        // Payload stays put while the block stalls.
      end else if (frame_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (frame_queue[0].drain && demap_expect.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        if (!gap_loaded) begin
          gap_left   = frame_queue[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= frame_queue[0].beat;
          in_valid <= 1'b1;
          void'(frame_queue.pop_front());
          gap_loaded = 1'b0;
        end
      end
    end
  end

  // Result receiver: a random stall before each beat while idle_on is set, and
  // now and then a long hold-off so that the block backs up into its input side.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken) begin
        stall_loaded = 1'b0;
        if (results_seen % 300 == 120) begin
          hold_left = HOLD_CYC;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (!stall_loaded) begin
          stall_left   = idle_on ? $urandom_range(0, 10) : 0;
          stall_loaded = 1'b1;
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(logic [pdr_pkg::CFG_IDX_W-1:0] idx,
                           logic [pdr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  // Loads plan_tbl and the count; the unused upper bits of the count word are random.
  task automatic load_mapping(logic [pdr_pkg::CNT_W-1:0] cnt);
    logic [pdr_pkg::CFG_DATA_W-1:0] word;
    word = {$urandom, $urandom};
    word[pdr_pkg::CNT_W-1:0] = cnt;
    write_reg(pdr_pkg::REG_MAP_COUNT, word);
    for (int p = 0; p < MAX_ENTRIES / 2; p++) begin
      write_reg(pdr_pkg::CFG_IDX_W'(int'(pdr_pkg::REG_MAP_PAIR_A) + p),
                {plan_tbl[2*p + 1], plan_tbl[2*p]});
    end
  endtask

  task automatic queue_frame(logic [pdr_pkg::DATA_W-1:0] bytes,
                             logic [pdr_pkg::LEN_W-1:0] len, bit drain);
    frame_job_t job;
    job.beat.frame_bytes  = bytes;
    job.beat.frame_length = len;
    job.gap   = idle_on ? $urandom_range(0, 10) : 0;
    job.drain = drain;
    frame_queue.push_back(job);
    frames_queued++;
  endtask

  // Waits until every queued frame is taken and every result has come, then
  // lets the walk of a frame with no results finish as well.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while ((frames_taken != frames_queued || demap_expect.size() != 0) && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned                remain, nb, pick, nb_max;
    bit                         wellformed;
    logic [pdr_pkg::CNT_W-1:0]  cnt;
    logic [pdr_pkg::LEN_W-1:0]  len;
    logic [pdr_pkg::DATA_W-1:0] bytes;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Table straight out of reset is empty: frames cause no results.
    queue_frame('1, pdr_pkg::LEN_W'(8), 1'b0);
    queue_frame('0, '0, 1'b0);
    settle();

    // Byte-aligned entries that fill eight bytes, then zero-byte entries of up to seven bits.
    plan_tbl[0] = {16'h1000, 8'h01, 8'd8};
    plan_tbl[1] = {16'h2000, 8'h02, 8'd16};
    plan_tbl[2] = {16'hFFFF, 8'hFF, 8'd32};
    plan_tbl[3] = {16'h0000, 8'h00, 8'd8};
    for (int k = 4; k < MAX_ENTRIES; k++) begin
      plan_tbl[k] = {16'h4000 + 16'(k), 8'(k), 8'($urandom_range(0, 7))};
    end
    load_mapping(pdr_pkg::CNT_W'(8));
    queue_frame('1, pdr_pkg::LEN_W'(8), 1'b0);
    queue_frame('0, pdr_pkg::LEN_W'(8), 1'b0);
    queue_frame(64'h0807_0605_0403_0201, pdr_pkg::LEN_W'(8), 1'b0);
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(15), 1'b0);
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(3), 1'b0);
    queue_frame({$urandom, $urandom}, '0, 1'b0);
    settle();

    // Count above the table size, odd bit lengths, a wide entry, an entry
    // that can never fit.
    plan_tbl[0] = {16'h1234, 8'h10, 8'd12};
    plan_tbl[1] = {16'h5678, 8'h20, 8'd40};
    plan_tbl[2] = {16'h9ABC, 8'h30, 8'd7};
    plan_tbl[3] = {16'hDEF0, 8'h40, 8'd255};
    for (int k = 4; k < MAX_ENTRIES; k++) plan_tbl[k] = $urandom;
    load_mapping('1);
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(8), 1'b0);
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(5), 1'b0);
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(6), 1'b0);
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(9), 1'b0);
    queue_frame('1, pdr_pkg::LEN_W'(15), 1'b0);
    settle();

    // All-ones table words; writes to the unmapped indexes must change nothing.
    foreach (plan_tbl[k]) plan_tbl[k] = '1;
    load_mapping(pdr_pkg::CNT_W'(8));
    for (int r = int'(pdr_pkg::REG_MAP_PAIR_D) + 1; r < (1 << pdr_pkg::CFG_IDX_W); r++) begin
      write_reg(pdr_pkg::CFG_IDX_W'(r), {$urandom, $urandom});
    end
    queue_frame('1, pdr_pkg::LEN_W'(8), 1'b0);
    settle();

    // A single 64-bit entry: only four bytes are copied.
    foreach (plan_tbl[k]) plan_tbl[k] = '0;
    plan_tbl[0] = {16'hA5A5, 8'h5A, 8'd64};
    load_mapping(pdr_pkg::CNT_W'(1));
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(8), 1'b0);
    queue_frame({$urandom, $urandom}, pdr_pkg::LEN_W'(7), 1'b0);
    settle();

    // Eight zero-length entries against an empty frame give eight results.
    foreach (plan_tbl[k]) plan_tbl[k] = {16'($urandom), 8'($urandom), 8'd0};
    load_mapping(pdr_pkg::CNT_W'(8));
    queue_frame({$urandom, $urandom}, '0, 1'b0);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on    = !(ph == 1 || ph == 6);
      wellformed = $urandom_range(0, 4) != 0;
      if (wellformed) begin
        remain = pdr_pkg::FRAME_BYTES;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
          nb_max = (remain < pdr_pkg::VALUE_BYTES) ? remain : pdr_pkg::VALUE_BYTES;
          nb = (remain == 0) ? 0 : $urandom_range(1, nb_max);
          remain -= nb;
          plan_tbl[k].object_index = 16'($urandom);
          plan_tbl[k].sub_index    = 8'($urandom);
          plan_tbl[k].bitlen       = 8'(nb * 8);
          // Occasional leftover bits push the later entries along.
          if ($urandom_range(0, 5) == 0) plan_tbl[k].bitlen += 8'($urandom_range(1, 7));
        end
        cnt = pdr_pkg::CNT_W'($urandom_range(1, MAX_ENTRIES));
      end else begin
        foreach (plan_tbl[k]) plan_tbl[k] = $urandom;
        cnt = pdr_pkg::CNT_W'($urandom_range(0, 15));
      end
      load_mapping(cnt);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 15)      len = pdr_pkg::LEN_W'(8);
        else if (pick < 18) len = pdr_pkg::LEN_W'($urandom_range(0, 8));
        else                len = pdr_pkg::LEN_W'($urandom_range(9, 15));
        pick = $urandom_range(0, 29);
        if (pick == 0)      bytes = '1;
        else if (pick == 1) bytes = '0;
        else                bytes = {$urandom, $urandom};
        queue_frame(bytes, len, (ph == 2 && i == 12) || $urandom_range(0, 24) == 0);
      end
      settle();
    end

    settle();
    if (demap_expect.size() != 0) begin
      report_error($sformatf("%0d expected results never came", demap_expect.size()));
    end
    $display("Run covered %0d frames and %0d result beats over %0d register writes.",
             frames_taken, results_seen, cfg_writes);
    $display("Receiver hold-offs: %0d; mismatches found: %0d.", holds_done, err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
